// ===== rtl/nsc_pkg.sv =====
// Package with shared types, codes and tables for the NMEA sentence checker.
`timescale 1ns / 1ps
package nsc_pkg;

  localparam int MAX_LENGTH_DEF = 128;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam int         NUM_TYPES   = 5;
  localparam int         HDR_LEN     = 5;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_NO_START = 3'd1;
  localparam logic [2:0] STATUS_NO_SUM   = 3'd2;
  localparam logic [2:0] STATUS_MISMATCH = 3'd3;
  localparam logic [2:0] STATUS_TOO_LONG = 3'd4;

  localparam logic [2:0] TYPE_NONE = 3'd0;

  localparam logic [4:0] HDR_ALL = 5'h1F;

  // GPGGA, GPGSA, GPGSV, GPRMC, GPVTG
  localparam logic [7:0] HDR_NAMES [NUM_TYPES][HDR_LEN] = '{
    '{8'h47, 8'h50, 8'h47, 8'h47, 8'h41},
    '{8'h47, 8'h50, 8'h47, 8'h53, 8'h41},
    '{8'h47, 8'h50, 8'h47, 8'h53, 8'h56},
    '{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},
    '{8'h47, 8'h50, 8'h56, 8'h54, 8'h47}
  };

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] sentence_type;
    logic       type_selected;
    logic [7:0] computed_checksum;
  } nsc_result_t;

  // Bit 4 set marks a non-hex character.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h61 + 8'd10);
    end else begin
      v = 5'd16;
    end
    return v;
  endfunction

endpackage

// ===== rtl/nmea_sentence_checker.sv =====
// Top level of the NMEA sentence checker.
`timescale 1ns / 1ps
// Usage:
//   Feed sentence bytes on the s_ stream, one byte per transfer, with s_tlast
//   high on the final byte. Every byte is checked; only the final byte of a
//   sentence produces a result transfer on the m_ stream carrying status,
//   sentence type, the type-selected flag and the computed XOR checksum.
//   The cfg channel writes the 5-bit type mask (GGA bit 0 .. VTG bit 4); it
//   is always ready and should be written only while no sentence is in flight.
// Timing:
//   One byte per cycle sustained while the result register is not stalled. After the
//   final byte transfers, the state update loads the result register from the
//   input register and m_tvalid rises; a held result can delay that update.
// Reset:
//   rst clears both pipeline registers and the sentence state, and sets the
//   type mask to GGA only.
// Stall:
//   While m_tvalid is high and m_tready is low, the result holds, the input
//   register holds its byte and s_tready drops once that register is full.
module nmea_sentence_checker
  import nsc_pkg::*;
#(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // data_byte[7:0]
  input  logic        s_tlast,    // end_of_sentence
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // status[2:0], sentence_type[5:3], type_selected[6],
                                  // computed_checksum[14:7], zero[15]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // type_mask[4:0]
);

  logic        type_mask_reg;
  logic [4:0]  type_mask;
  logic        free;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        step;
  nsc_result_t result;

  assign cfg_ready     = 1'b1;
  assign type_mask_reg = cfg_valid && cfg_ready;
  assign step          = in_valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_mask <= 5'd1;
    end else if (type_mask_reg) begin
      type_mask <= cfg_data;
    end
  end

  nsc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .advance  (free),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_last  (in_last)
  );

  nsc_track #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_track (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .data_byte       (in_byte),
    .end_of_sentence (in_last),
    .type_mask       (type_mask),
    .result          (result)
  );

  nsc_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (step && in_last),
    .result   (result),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== rtl/nsc_in_reg.sv =====
// Input register stage for incoming sentence bytes.
`timescale 1ns / 1ps
module nsc_in_reg
  import nsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte[7:0]
  input  logic       s_tlast,   // end_of_sentence
  input  logic       advance,
  output logic       in_valid,
  output logic [7:0] in_byte,
  output logic       in_last
);

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

endmodule

// ===== rtl/nsc_track.sv =====
// Per-sentence running state: checksum, header match, digits and result logic.
`timescale 1ns / 1ps
module nsc_track
  import nsc_pkg::*;
#(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        end_of_sentence,
  input  logic [4:0]  type_mask,
  output nsc_result_t result
);

  localparam logic [7:0] LEN_LIMIT = 8'(MAX_LENGTH - 1);

  logic [7:0] byte_position;
  logic [7:0] running_xor;
  logic       star_seen;
  logic [1:0] digits_seen;
  logic [7:0] received_sum;
  logic       digit_bad;
  logic       start_ok;
  logic [4:0] header_match;

  logic [7:0] byte_position_next;
  logic [7:0] running_xor_next;
  logic       star_seen_next;
  logic [1:0] digits_seen_next;
  logic [7:0] received_sum_next;
  logic       digit_bad_next;
  logic       start_ok_next;
  logic [4:0] header_match_next;

  always_comb begin
    logic [4:0] hv;
    logic [2:0] hpos;
    logic [2:0] ty;
    logic [5:0] mask_ext;
    byte_position_next = (byte_position != 8'd255) ? byte_position + 8'd1 : byte_position;
    running_xor_next   = running_xor;
    star_seen_next     = star_seen;
    digits_seen_next   = digits_seen;
    received_sum_next  = received_sum;
    digit_bad_next     = digit_bad;
    start_ok_next      = start_ok;
    header_match_next  = header_match;
    hv   = hex_value(data_byte);
    hpos = 3'(byte_position - 8'd1);
    if (byte_position == 8'd0) begin
      start_ok_next = (data_byte == CHAR_DOLLAR);
    end else begin
      if (byte_position <= 8'(HDR_LEN)) begin
        for (int k = 0; k < NUM_TYPES; k++) begin
          if (HDR_NAMES[k][hpos] != data_byte) begin
            header_match_next[k] = 1'b0;
          end
        end
      end
      if (!star_seen) begin
        if (data_byte == CHAR_STAR) begin
          star_seen_next = 1'b1;
        end else begin
          running_xor_next = running_xor ^ data_byte;
        end
      end else if (digits_seen < 2'd2) begin
        if (hv[4]) begin
          digit_bad_next    = 1'b1;
          received_sum_next = {received_sum[3:0], 4'd0};
        end else begin
          received_sum_next = {received_sum[3:0], hv[3:0]};
        end
        digits_seen_next = digits_seen + 2'd1;
      end
    end

    if (byte_position >= LEN_LIMIT) begin
      result.status = STATUS_TOO_LONG;
    end else if (!start_ok_next) begin
      result.status = STATUS_NO_START;
    end else if (!star_seen_next || digits_seen_next < 2'd2 || digit_bad_next) begin
      result.status = STATUS_NO_SUM;
    end else if (received_sum_next != running_xor_next) begin
      result.status = STATUS_MISMATCH;
    end else begin
      result.status = STATUS_OK;
    end

    ty = TYPE_NONE;
    if (byte_position >= 8'(HDR_LEN)) begin
      for (int k = NUM_TYPES - 1; k >= 0; k--) begin
        if (header_match_next[k]) begin
          ty = 3'(k + 1);
        end
      end
    end
    mask_ext = {type_mask, 1'b0};
    result.sentence_type     = ty;
    result.type_selected     = (ty != TYPE_NONE) && mask_ext[ty];
    result.computed_checksum = running_xor_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_sentence)) begin
      byte_position <= 8'd0;
      running_xor   <= 8'd0;
      star_seen     <= 1'b0;
      digits_seen   <= 2'd0;
      received_sum  <= 8'd0;
      digit_bad     <= 1'b0;
      start_ok      <= 1'b0;
      header_match  <= HDR_ALL;
    end else if (step) begin
      byte_position <= byte_position_next;
      running_xor   <= running_xor_next;
      star_seen     <= star_seen_next;
      digits_seen   <= digits_seen_next;
      received_sum  <= received_sum_next;
      digit_bad     <= digit_bad_next;
      start_ok      <= start_ok_next;
      header_match  <= header_match_next;
    end
  end

endmodule

// ===== rtl/nsc_out_reg.sv =====
// Result register driving the output stream.
`timescale 1ns / 1ps
module nsc_out_reg
  import nsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  nsc_result_t result,
  output logic        free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // status[2:0], sentence_type[5:3], type_selected[6],
                                // computed_checksum[14:7], zero[15]
);

  nsc_result_t held;

  assign free    = !m_tvalid || m_tready;
  assign m_tdata = {1'b0, held.computed_checksum, held.type_selected,
                    held.sentence_type, held.status};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= result;
    end
  end

endmodule

// ===== tb/nmea_sentence_checker_tb.sv =====
// Self-checking testbench for the NMEA sentence checker with its own sentence predictor.
`timescale 1ns / 1ps
module nmea_sentence_checker_tb;
  import nsc_pkg::*;

  localparam int SENT_LIMIT = 128;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES = 300;
  localparam logic [39:0] SENT_NAMES [NUM_TYPES] = '{"GPGGA", "GPGSA", "GPGSV", "GPRMC", "GPVTG"};
  localparam logic [7:0] NOT_HEX [6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] kind;
    logic       sel;
    logic [7:0] xsum;
  } sentence_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;

  // sentence state of the predictor
  logic [7:0] cur_pos;
  logic [7:0] sum_xor;
  logic       got_star;
  logic [1:0] n_digits;
  logic [7:0] rx_sum;
  logic       bad_digit;
  logic       saw_dollar;
  logic [4:0] hdr_alive;
  logic [4:0] mask_model;

  sentence_result_t pending_results[$];
  logic [7:0] line_buf[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  bit hold_req = 0;
  int err_count = 0;
  int results_checked = 0;
  int bytes_sent = 0;
  int sentences_sent = 0;
  int masks_written = 0;
  int status_hist [5] = '{default: 0};

  nmea_sentence_checker #(
    .MAX_LENGTH(SENT_LIMIT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #5_000_000;
    $display("** nmea_sentence_checker: FAILED **");
    $finish;
  end

  function automatic void clear_sentence_model();
    cur_pos = '0;
    sum_xor = '0;
    got_star = 1'b0;
    n_digits = '0;
    rx_sum = '0;
    bad_digit = 1'b0;
    saw_dollar = 1'b0;
    hdr_alive = HDR_ALL;
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 10)};
    return 5'h10;
  endfunction

  function automatic bit predict_byte(input logic [7:0] b, input bit is_final,
                                      output sentence_result_t r);
    logic [7:0] pos;
    logic [4:0] nib;
    pos = cur_pos;
    r = '0;
    if (pos == 0) begin
      saw_dollar = (b == CHAR_DOLLAR);
    end else begin
      if (pos <= HDR_LEN) begin
        for (int k = 0; k < NUM_TYPES; k++) begin
          if (SENT_NAMES[k][39 - 8 * (pos - 1) -: 8] != b) hdr_alive[k] = 1'b0;
        end
      end
      if (!got_star) begin
        if (b == CHAR_STAR) got_star = 1'b1;
        else sum_xor = sum_xor ^ b;
      end else if (n_digits < 2) begin
        nib = hex_nibble(b);
        if (nib[4]) begin
          bad_digit = 1'b1;
          nib = '0;
        end
        rx_sum = {rx_sum[3:0], nib[3:0]};
        n_digits = n_digits + 1'b1;
      end
    end
    if (cur_pos != 8'hFF) cur_pos = cur_pos + 1'b1;
    if (!is_final) return 1'b0;

    if (int'(pos) + 1 >= SENT_LIMIT) r.status = STATUS_TOO_LONG;
    else if (!saw_dollar) r.status = STATUS_NO_START;
    else if (!got_star || n_digits < 2 || bad_digit) r.status = STATUS_NO_SUM;
    else if (rx_sum != sum_xor) r.status = STATUS_MISMATCH;
    else r.status = STATUS_OK;

    r.kind = TYPE_NONE;
    if (pos >= 5) begin
      for (int k = NUM_TYPES - 1; k >= 0; k--) begin
        if (hdr_alive[k]) r.kind = 3'(k + 1);
      end
    end
    r.sel = (r.kind != TYPE_NONE) && mask_model[r.kind - 1];
    r.xsum = sum_xor;
    clear_sentence_model();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("MISMATCH at %0t: %s expected %0d got %0d (result %0d)",
             $time, what, exp_v, got_v, results_checked);
    err_count++;
  endtask

  always @(posedge clk) begin
    sentence_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, data", 0, m_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[2:0] != exp_r.status)
          report_mismatch("status", exp_r.status, m_tdata[2:0]);
        if (m_tdata[5:3] != exp_r.kind)
          report_mismatch("sentence_type", exp_r.kind, m_tdata[5:3]);
        if (m_tdata[6] != exp_r.sel)
          report_mismatch("type_selected", exp_r.sel, m_tdata[6]);
        if (m_tdata[14:7] != exp_r.xsum)
          report_mismatch("computed_checksum", exp_r.xsum, m_tdata[14:7]);
        status_hist[exp_r.status]++;
      end
      results_checked++;
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit is_final);
    sentence_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= is_final;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (predict_byte(b, is_final, r)) begin
      pending_results.push_back(r);
      sentences_sent++;
    end
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  // drop valid, wait for every pending result, then let the pipeline empty
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [4:0] m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    mask_model = m;
    masks_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
  endfunction

  // append star and the two-digit checksum of everything after the first byte, xor flip
  function automatic void put_checked(input logic [7:0] flip);
    logic [7:0] v;
    v = flip;
    for (int i = 1; i < line_buf.size(); i++) v = v ^ line_buf[i];
    line_buf.push_back(CHAR_STAR);
    line_buf.push_back(hex_char(v[7:4]));
    line_buf.push_back(hex_char(v[3:0]));
  endfunction

  function automatic void put_name(input int k);
    for (int i = 0; i < HDR_LEN; i++) line_buf.push_back(SENT_NAMES[k][39 - 8 * i -: 8]);
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == CHAR_STAR);
    return c;
  endfunction

  task automatic test_basic_sentences();
    put_str("$GPGGA,1");
    put_checked(8'h00);
    send_line();
    put_str("$GPVTG,9.5");
    put_checked(8'h00);
    send_line();
    put_str("$GPGSA");
    put_checked(8'h5A);
    send_line();
    put_str("X");
    send_line();
    put_str("$");
    send_line();
    put_str("$GP*4");
    send_line();
    put_str("$GPGSV*zz");
    send_line();
    put_str("GPRMC");
    put_checked(8'h00);
    send_line();
    put_str("$GPGGA,,");
    put_checked(8'h00);
    line_buf.push_back(8'h0D);
    line_buf.push_back(8'h0A);
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h00);
    send_line();
  endtask

  task automatic test_type_mask();
    logic [4:0] masks [4];
    masks = '{5'h00, 5'h1F, 5'b01010, 5'($urandom_range(31))};
    foreach (masks[m]) begin
      drain();
      write_mask(masks[m]);
      for (int k = 0; k < NUM_TYPES; k++) begin
        line_buf.push_back(CHAR_DOLLAR);
        put_name(k);
        put_checked(8'h00);
        send_line();
      end
      put_str("$GPXYZ");
      put_checked(8'h00);
      send_line();
    end
  endtask

  task automatic test_length_limit();
    int lens [3];
    lens = '{SENT_LIMIT - 1, SENT_LIMIT, 260};
    foreach (lens[i]) begin
      line_buf.push_back(CHAR_DOLLAR);
      put_name(3);
      repeat (lens[i] - 9) line_buf.push_back(",");
      put_checked(8'h00);
      send_line();
    end
  endtask

  // hold the result side for a long stretch while sentences keep coming
  task automatic test_output_stall();
    drain();
    rx_idle_pct = 0;
    tx_idle_pct = 0;
    hold_req = 1'b1;
    repeat (8) begin
      line_buf.push_back(CHAR_DOLLAR);
      put_name($urandom_range(NUM_TYPES - 1));
      put_checked(8'h00);
      send_line();
    end
    drain();
  endtask

  task automatic build_random_line();
    int pick;
    int n;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 8) begin
      n = $urandom_range(1, 20);
      repeat (n) line_buf.push_back(8'($urandom_range(255)));
      return;
    end
    if (pick < 14) begin
      n = $urandom_range(1, 6);
      line_buf.push_back($urandom_range(1) ? CHAR_DOLLAR : "G");
      repeat (n - 1) line_buf.push_back(text_char());
      return;
    end
    if (pick < 20) begin
      do c = 8'($urandom_range(255)); while (c == CHAR_DOLLAR);
    end else begin
      c = CHAR_DOLLAR;
    end
    line_buf.push_back(c);
    if (pick >= 20 && pick < 25) begin
      put_str("GP");
      line_buf.push_back(CHAR_STAR);
    end else if ($urandom_range(99) < 85) begin
      put_name($urandom_range(NUM_TYPES - 1));
    end else begin
      put_str("GP");
      repeat (3) line_buf.push_back(8'($urandom_range("A", "Z")));
    end
    n = (pick >= 25 && pick < 30) ? $urandom_range(112, 130) : $urandom_range(0, 12);
    repeat (n) line_buf.push_back(text_char());
    if (pick >= 30 && pick < 40) begin
      case ($urandom_range(3))
        0: ;
        1: line_buf.push_back(CHAR_STAR);
        2: begin
          line_buf.push_back(CHAR_STAR);
          line_buf.push_back(hex_char(4'($urandom_range(15))));
        end
        default: begin
          line_buf.push_back(CHAR_STAR);
          if ($urandom_range(1)) line_buf.push_back(hex_char(4'($urandom_range(15))));
          line_buf.push_back(NOT_HEX[$urandom_range(5)]);
          if (line_buf[line_buf.size() - 2] == CHAR_STAR)
            line_buf.push_back(hex_char(4'($urandom_range(15))));
        end
      endcase
    end else begin
      put_checked($urandom_range(99) < 80 ? 8'h00 : 8'($urandom_range(1, 255)));
    end
    if ($urandom_range(99) < 25) begin
      n = $urandom_range(1, 3);
      repeat (n) line_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_traffic(input int n_bytes, input int tx_pct, input int rx_pct);
    int stop_at;
    drain();
    write_mask(5'($urandom_range(31)));
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      build_random_line();
      send_line();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mask_model = 5'h01;
    clear_sentence_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_sentences();
    test_type_mask();
    test_length_limit();
    test_output_stall();
    test_random_traffic(220, 25, 87);
    test_random_traffic(220, 87, 25);
    test_random_traffic(220, 0, 0);
    drain();

    if (pending_results.size() != 0)
      report_mismatch("results left undelivered", 0, pending_results.size());
    $display("Run covered %0d sentences in %0d bytes with %0d mask writes and %0d results",
             sentences_sent, bytes_sent, masks_written, results_checked);
    $display("By status: ok %0d, no start %0d, no checksum %0d, mismatch %0d, too long %0d",
             status_hist[0], status_hist[1], status_hist[2], status_hist[3], status_hist[4]);
    if (err_count == 0) begin
      $display("** nmea_sentence_checker: PASSED **");
    end else begin
      $display("** nmea_sentence_checker: FAILED **");
    end
    $finish;
  end

endmodule
